FILE: sv/lbac_pkg.sv
// lbac_pkg: shared types and constants of the lattice block adjacency classifier
// used by lbac_split and lattice_block_adjacency_classifier
package lbac_pkg;

  localparam int AXIS_BITS  = 10;
  localparam int ID_BITS    = 3 * AXIS_BITS;
  localparam int REG_BITS   = AXIS_BITS + 1;
  localparam int PLANE_BITS = 2 * AXIS_BITS + 1;

  // register indexes
  localparam logic [1:0] REG_PARTITION_X = 2'd0;
  localparam logic [1:0] REG_PARTITION_Y = 2'd1;
  localparam logic [1:0] REG_PARTITION_Z = 2'd2;

  // contact classes
  localparam logic [2:0] CLASS_NONE   = 3'd0;
  localparam logic [2:0] CLASS_FACE   = 3'd1;
  localparam logic [2:0] CLASS_EDGE   = 3'd2;
  localparam logic [2:0] CLASS_CORNER = 3'd3;
  localparam logic [2:0] CLASS_SELF   = 3'd4;

  localparam logic [REG_BITS-1:0] PART_MAX = REG_BITS'(1) << AXIS_BITS;

  typedef struct packed {
    logic [ID_BITS-1:0] id_first;
    logic [ID_BITS-1:0] id_second;
  } in_item_t;

  typedef struct packed {
    logic [AXIS_BITS-1:0] first_x;
    logic [AXIS_BITS-1:0] first_y;
    logic [AXIS_BITS-1:0] first_z;
    logic [AXIS_BITS-1:0] second_x;
    logic [AXIS_BITS-1:0] second_y;
    logic [AXIS_BITS-1:0] second_z;
    logic [2:0]           contact_class;
    logic                 out_of_range;
  } out_item_t;

  // coordinates of one block leaving the splitter
  typedef struct packed {
    logic [AXIS_BITS-1:0] x;
    logic [AXIS_BITS-1:0] y;
    logic [AXIS_BITS-1:0] z;
    logic                 ok;
  } coord_t;

  // zero acts as one, anything above the axis limit saturates
  function automatic logic [REG_BITS-1:0] eff_part(input logic [REG_BITS-1:0] v);
    logic [REG_BITS-1:0] r;
    if (v == '0) begin
      r = REG_BITS'(1);
    end else if (v > PART_MAX) begin
      r = PART_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: sv/lbac_split.sv
// lbac_split: pipelined restoring divider that splits a linear id into x, y, z
// depends on lbac_pkg
module lbac_split import lbac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ID_BITS-1:0]    id_i,
  input  logic [REG_BITS-1:0]   px_i,
  input  logic [PLANE_BITS-1:0] plane_i,
  input  logic [REG_BITS-1:0]   pz_i,
  output coord_t                coord_o
);

  localparam int N  = AXIS_BITS;
  localparam int RW = ID_BITS + 1;

  logic [RW-1:0]    rem_q [0:2*N];
  logic [2*N-1:0]   quo_q [1:2*N];
  logic             ok_q  [1:2*N];

  // input register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {1'b0, id_i};
    end
  end

  // one quotient bit per stage: z bits against plane, then y bits against px
  for (genvar s = 1; s <= 2 * N; s++) begin : g_stage
    logic [RW-1:0]  div;
    logic [RW-1:0]  rem_in;
    logic           bit_q;
    logic [RW-1:0]  rem_d;

    if (s <= N) begin : g_z
      assign div = RW'(plane_i) << (N - s);
    end else begin : g_y
      assign div = RW'(px_i) << (2 * N - s);
    end

    assign rem_in = rem_q[s-1];
    assign bit_q  = (rem_in >= div);
    assign rem_d  = bit_q ? (rem_in - div) : rem_in;

    if (s == 1) begin : g_first
      // z would not fit in N bits: id lies beyond any lattice depth
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          quo_q[s] <= {{(2*N-1){1'b0}}, bit_q};
          ok_q[s]  <= (rem_in < (RW'(plane_i) << N));
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          quo_q[s] <= {quo_q[s-1][2*N-2:0], bit_q};
          ok_q[s]  <= ok_q[s-1];
        end
      end
    end
  end

  // quotient holds z then y; the remainder is x; in range when z is below pz
  assign coord_o.z  = quo_q[2*N][2*N-1:N];
  assign coord_o.y  = quo_q[2*N][N-1:0];
  assign coord_o.x  = rem_q[2*N][N-1:0];
  assign coord_o.ok = ok_q[2*N] && (REG_BITS'(quo_q[2*N][2*N-1:N]) < pz_i);

endmodule

FILE: sv/lattice_block_adjacency_classifier.sv
// lattice_block_adjacency_classifier: top level, config registers, pipeline control
// depends on lbac_pkg and lbac_split
// path from input transfer to result: the input register, then 20 divider stages
// behind it, then one output register; the dividers resolve one quotient bit per stage
// throughput: one id pair per cycle; a stalled output holds the whole pipeline
// reset: partition registers and the plane size go to 1 and all valid bits clear
module lattice_block_adjacency_classifier import lbac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [REG_BITS-1:0] cfg_data_i
);

  localparam int N     = AXIS_BITS;
  localparam int DEPTH = 2 * N + 1;

  logic [REG_BITS-1:0]   px_q, py_q, pz_q;
  logic [PLANE_BITS-1:0] plane_q;
  logic [DEPTH-1:0]      valid_q;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;
  logic                  en;
  coord_t                ca, cb;

  // configuration writes, stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= REG_BITS'(1);
      py_q <= REG_BITS'(1);
      pz_q <= REG_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PARTITION_X: px_q <= eff_part(cfg_data_i);
        REG_PARTITION_Y: py_q <= eff_part(cfg_data_i);
        REG_PARTITION_Z: pz_q <= eff_part(cfg_data_i);
        default: ;
      endcase
    end
  end

  // plane size, one multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= PLANE_BITS'(1);
    end else begin
      plane_q <= PLANE_BITS'(px_q) * PLANE_BITS'(py_q);
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // valid bits travel with the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[DEPTH-2:0], in_valid_i};
      out_valid_q <= valid_q[DEPTH-1];
    end
  end

  lbac_split u_split_a (
    .clk_i   (clk_i),
    .en_i    (en),
    .id_i    (in_data_i.id_first),
    .px_i    (px_q),
    .plane_i (plane_q),
    .pz_i    (pz_q),
    .coord_o (ca)
  );

  lbac_split u_split_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .id_i    (in_data_i.id_second),
    .px_i    (px_q),
    .plane_i (plane_q),
    .pz_i    (pz_q),
    .coord_o (cb)
  );

  // contact classification
  always_comb begin
    logic [N-1:0] dx, dy, dz;
    logic         near;
    logic [1:0]   zeros;
    logic         both_ok;
    dx      = (ca.x > cb.x) ? (ca.x - cb.x) : (cb.x - ca.x);
    dy      = (ca.y > cb.y) ? (ca.y - cb.y) : (cb.y - ca.y);
    dz      = (ca.z > cb.z) ? (ca.z - cb.z) : (cb.z - ca.z);
    near    = (dx <= N'(1)) && (dy <= N'(1)) && (dz <= N'(1));
    zeros   = 2'(dx == '0) + 2'(dy == '0) + 2'(dz == '0);
    both_ok = ca.ok && cb.ok;

    out_d.first_x  = ca.ok ? ca.x : '0;
    out_d.first_y  = ca.ok ? ca.y : '0;
    out_d.first_z  = ca.ok ? ca.z : '0;
    out_d.second_x = cb.ok ? cb.x : '0;
    out_d.second_y = cb.ok ? cb.y : '0;
    out_d.second_z = cb.ok ? cb.z : '0;
    out_d.out_of_range = !both_ok;

    if (!both_ok || !near) begin
      out_d.contact_class = CLASS_NONE;
    end else if (zeros == 2'd3) begin
      out_d.contact_class = CLASS_SELF;
    end else if (zeros == 2'd2) begin
      out_d.contact_class = CLASS_FACE;
    end else if (zeros == 2'd1) begin
      out_d.contact_class = CLASS_EDGE;
    end else begin
      out_d.contact_class = CLASS_CORNER;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an id outside the lattice never touches anything
  a_oor_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_of_range) |-> (out_data_o.contact_class == CLASS_NONE))
    else $error("out of range result with a contact class");

  // same block means identical coordinates
  a_self_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.contact_class == CLASS_SELF) |->
      (out_data_o.first_x == out_data_o.second_x &&
       out_data_o.first_y == out_data_o.second_y &&
       out_data_o.first_z == out_data_o.second_z))
    else $error("same block class with differing coordinates");

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule
